// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file mhnt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/mhnt_pkg.sv -----
// Shared constants and controller/datapath interface types of the hanging note tracker.
`timescale 1ns / 1ps

package mhnt_pkg;

   localparam logic [2:0] CMD_MESSAGE = 3'd0;
   localparam logic [2:0] CMD_ADVANCE = 3'd1;
   localparam logic [2:0] CMD_CHECK   = 3'd2;
   localparam logic [2:0] CMD_STOP    = 3'd3;
   localparam logic [2:0] CMD_REFRESH = 3'd4;

   localparam int         CSR_INDEX_BITS     = 2;
   localparam int         CSR_DATA_BITS      = 32;
   localparam logic [1:0] CSR_MASTER_VOLUME  = 2'd0;
   localparam logic [1:0] CSR_MAX_NOTE_STEPS = 2'd1;
   localparam logic [1:0] CSR_GLOBAL_VOLUME  = 2'd2;

   localparam logic [8:0]  MASTER_VOLUME_RESET  = 9'd256;
   localparam logic [31:0] MAX_NOTE_STEPS_RESET = 32'd1920;

   localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
   localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
   localparam logic [3:0] TYPE_CONTROL  = 4'hB;
   localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
   localparam logic [6:0] CTRL_VOLUME   = 7'd7;
   localparam logic [6:0] VOLUME_RESET  = 7'd127;

   localparam logic [1:0] LEN_SHORT = 2'd2;
   localparam logic [1:0] LEN_FULL  = 2'd3;

   typedef enum logic [1:0] {
      EMIT_MESSAGE  = 2'd0,
      EMIT_NOTE_OFF = 2'd1,
      EMIT_VOLUME   = 2'd2
   } emit_sel_type;

   typedef struct packed {
      logic         latch_req;
      logic         act_rd;
      logic         load_mask;
      logic         rel_load_act;
      logic         rel_clr;
      logic         scan_rd;
      logic         cnt_clr;
      logic         cnt_inc;
      logic         emit;
      emit_sel_type emit_sel;
      logic         msg_commit;
      logic         finish_write;
      logic         time_adv;
      logic         time_clear;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] command;
      logic       key_ok;
      logic       global_mode;
      logic       rel_empty;
      logic       cnt_last;
      logic       slot_free;
   } dp_status_type;

endpackage

// ----- hw/rtl/mhnt_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mhnt_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mhnt_datapath.sv -----
// Datapath: request, config and time registers, key/start-time memories, output register.
`timescale 1ns / 1ps

module mhnt_datapath import mhnt_pkg::*; #(
   parameter int KEY_COUNT     = 128,
   parameter int CHANNEL_COUNT = 16,
   parameter int TIME_BITS     = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [2:0]                req_command,
   input  logic [7:0]                req_status_byte,
   input  logic [6:0]                req_data_first,
   input  logic [6:0]                req_data_second,
   input  logic [15:0]               req_elapsed_steps,
   input  logic [6:0]                req_key_index,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output logic [7:0]                rsp_out_status,
   output logic [6:0]                rsp_out_data_first,
   output logic [6:0]                rsp_out_data_second,
   output logic [1:0]                rsp_out_length,
   output logic                      rsp_last_of_run
);

   localparam int KEY_AW   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int CH_AW    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int ST_DEPTH = KEY_COUNT * CHANNEL_COUNT;
   localparam int ST_AW    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
   localparam int CMP_W    = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam logic [7:0] KEY_LIMIT = 8'(KEY_COUNT);
   localparam logic [4:0] CH_LIMIT  = 5'(CHANNEL_COUNT);
   localparam logic [CHANNEL_COUNT-1:0] ONE_CH = CHANNEL_COUNT'(1);
   localparam logic [CH_AW-1:0] CH_LAST = CH_AW'(CHANNEL_COUNT - 1);

   // request registers
   logic [2:0]  cmd_ff,  cmd_in;
   logic [7:0]  st_ff,   st_in;
   logic [6:0]  d1_ff,   d1_in;
   logic [6:0]  d2_ff,   d2_in;
   logic [15:0] el_ff,   el_in;
   logic [6:0]  key_ff,  key_in;

   // configuration
   logic [8:0]  master_ff, master_in;
   logic [31:0] max_ff,    max_in;
   logic        global_ff, global_in;

   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [6:0]           vol_ff [CHANNEL_COUNT];

   logic [CHANNEL_COUNT-1:0] mask_ff, mask_in;
   logic [CHANNEL_COUNT-1:0] rel_ff,  rel_in;
   logic [CH_AW-1:0]         cnt_ff,  cnt_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [CH_AW-1:0]         cmp_ch_ff,  cmp_ch_in;

   logic [KEY_COUNT-1:0]     act_vld_ff;
   logic                     act_rd_vld_ff;
   logic                     act_we;
   logic [KEY_AW-1:0]        act_addr;
   logic [CHANNEL_COUNT-1:0] act_wdata, act_rdata, act_rdata_eff;
   logic [6:0]               act_key;

   logic                 st_we;
   logic [ST_AW-1:0]     st_wr_addr, st_rd_addr;
   logic [TIME_BITS-1:0] st_rdata, held;
   logic                 overlong;

   logic [3:0]               type_nib, ch;
   logic [CH_AW-1:0]         ch_idx;
   logic [CHANNEL_COUNT-1:0] ch_bit;
   logic                     ch_ok, key_ok, note_ok, note_on, vol_ctl;

   logic [CHANNEL_COUNT-1:0] rel_low;
   logic [CH_AW-1:0]         rel_ch;
   logic                     rel_rest_empty, cnt_last;

   logic [6:0]  vol_src, scaled;
   logic [15:0] prod;
   logic [17:0] prod3;

   logic       out_valid_ff, out_valid_in, slot_free;
   logic [7:0] out_st_ff, out_st_in;
   logic [6:0] out_d1_ff, out_d1_in;
   logic [6:0] out_d2_ff, out_d2_in;
   logic [1:0] out_len_ff, out_len_in;
   logic       out_last_ff, out_last_in;

   // decode of the held request
   assign type_nib = st_ff[7:4];
   assign ch       = st_ff[3:0];
   assign ch_idx   = ch[CH_AW-1:0];
   assign ch_bit   = ONE_CH << ch_idx;
   assign ch_ok    = {1'b0, ch} < CH_LIMIT;
   assign key_ok   = {1'b0, key_ff} < KEY_LIMIT;
   assign note_ok  = ((type_nib == TYPE_NOTE_ON) || (type_nib == TYPE_NOTE_OFF)) &&
                     ({1'b0, d1_ff} < KEY_LIMIT) && ch_ok;
   assign note_on  = (type_nib == TYPE_NOTE_ON) && (d2_ff != 7'd0);
   assign vol_ctl  = (type_nib == TYPE_CONTROL) && (d1_ff == CTRL_VOLUME) && !global_ff;
   assign cnt_last = cnt_ff == CH_LAST;

   // per-key active channel masks, invalid entries read as zero
   assign act_key       = (cmd_ff == CMD_MESSAGE) ? d1_ff : key_ff;
   assign act_addr      = act_key[KEY_AW-1:0];
   assign act_rdata_eff = act_rd_vld_ff ? act_rdata : '0;
   assign act_we        = (cmd.msg_commit && note_ok) || cmd.finish_write;
   assign act_wdata     = cmd.finish_write ? mask_ff :
                          (note_on ? (mask_ff | ch_bit) : (mask_ff & ~ch_bit));

   mhnt_ram #(
      .WIDTH (CHANNEL_COUNT),
      .DEPTH (KEY_COUNT)
   ) u_act_ram (
      .clock   (clock),
      .wr_en   (act_we),
      .wr_addr (act_addr),
      .wr_data (act_wdata),
      .rd_en   (cmd.act_rd),
      .rd_addr (act_addr),
      .rd_data (act_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         act_vld_ff <= '0;
      end else if (act_we) begin
         act_vld_ff[act_addr] <= 1'b1;
      end
      if (cmd.act_rd) begin
         act_rd_vld_ff <= act_vld_ff[act_addr];
      end
   end

   // note start times, one entry per key and channel
   assign st_we      = cmd.msg_commit && note_ok && note_on;
   assign st_wr_addr = ST_AW'(d1_ff[KEY_AW-1:0]) * ST_AW'(CHANNEL_COUNT) + ST_AW'(ch_idx);
   assign st_rd_addr = ST_AW'(key_ff[KEY_AW-1:0]) * ST_AW'(CHANNEL_COUNT) + ST_AW'(cnt_ff);

   mhnt_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (ST_DEPTH)
   ) u_start_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_wr_addr),
      .wr_data (time_ff),
      .rd_en   (cmd.scan_rd),
      .rd_addr (st_rd_addr),
      .rd_data (st_rdata)
   );

   assign held     = time_ff - st_rdata;
   assign overlong = CMP_W'(held) > CMP_W'(max_ff);

   // lowest pending release
   assign rel_low        = rel_ff & (~rel_ff + ONE_CH);
   assign rel_rest_empty = (rel_ff & ~rel_low) == '0;

   always_comb begin
      rel_ch = '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         rel_ch = rel_ch | (rel_low[i] ? CH_AW'(i) : '0);
      end
   end

   // volume scaling: vol * master * 3 / 1024, saturated
   assign vol_src = (cmd.emit_sel == EMIT_VOLUME) ? vol_ff[cnt_ff] : d2_ff;
   assign prod    = 16'(vol_src) * 16'(master_ff);
   assign prod3   = {1'b0, prod, 1'b0} + 18'(prod);
   assign scaled  = (prod3[17:10] > 8'd127) ? 7'd127 : prod3[16:10];

   assign slot_free = !out_valid_ff || rsp_tready;

   always_comb begin
      cmd_in    = cmd_ff;
      st_in     = st_ff;
      d1_in     = d1_ff;
      d2_in     = d2_ff;
      el_in     = el_ff;
      key_in    = key_ff;
      master_in = master_ff;
      max_in    = max_ff;
      global_in = global_ff;
      time_in   = time_ff;
      mask_in   = mask_ff;
      rel_in    = rel_ff;
      cnt_in    = cnt_ff;
      cmp_vld_in = cmd.scan_rd;
      cmp_ch_in  = cnt_ff;

      if (cmd.latch_req) begin
         cmd_in = req_command;
         st_in  = req_status_byte;
         d1_in  = req_data_first;
         d2_in  = req_data_second;
         el_in  = req_elapsed_steps;
         key_in = req_key_index;
      end

      if (csr_wr_en) begin
         case (csr_index)
            CSR_MASTER_VOLUME:  master_in = csr_wdata[8:0];
            CSR_MAX_NOTE_STEPS: max_in    = csr_wdata[31:0];
            CSR_GLOBAL_VOLUME:  global_in = csr_wdata[0];
            default:            ;
         endcase
      end

      if (cmd.time_adv) begin
         time_in = time_ff + TIME_BITS'(el_ff);
      end else if (cmd.time_clear) begin
         time_in = '0;
      end

      if (cmd.load_mask) begin
         mask_in = act_rdata_eff;
      end else if (cmd.emit && (cmd.emit_sel == EMIT_NOTE_OFF)) begin
         mask_in = mask_ff & ~rel_low;
      end

      if (cmd.rel_clr) begin
         rel_in = '0;
      end else if (cmd.rel_load_act) begin
         rel_in = act_rdata_eff;
      end else if (cmp_vld_ff && mask_ff[cmp_ch_ff] && overlong) begin
         rel_in = rel_ff | (ONE_CH << cmp_ch_ff);
      end else if (cmd.emit && (cmd.emit_sel == EMIT_NOTE_OFF)) begin
         rel_in = rel_ff & ~rel_low;
      end

      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.scan_rd || cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // result formation
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_st_in    = out_st_ff;
      out_d1_in    = out_d1_ff;
      out_d2_in    = out_d2_ff;
      out_len_in   = out_len_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         case (cmd.emit_sel)
            EMIT_MESSAGE: begin
               out_st_in   = st_ff;
               out_d1_in   = d1_ff;
               out_d2_in   = (type_nib == TYPE_PROGRAM) ? 7'd0 : (vol_ctl ? scaled : d2_ff);
               out_len_in  = (type_nib == TYPE_PROGRAM) ? LEN_SHORT : LEN_FULL;
               out_last_in = 1'b1;
            end
            EMIT_NOTE_OFF: begin
               out_st_in   = {TYPE_NOTE_OFF, 4'(rel_ch)};
               out_d1_in   = key_ff;
               out_d2_in   = 7'd0;
               out_len_in  = LEN_FULL;
               out_last_in = rel_rest_empty;
            end
            EMIT_VOLUME: begin
               out_st_in   = {TYPE_CONTROL, 4'(cnt_ff)};
               out_d1_in   = CTRL_VOLUME;
               out_d2_in   = scaled;
               out_len_in  = LEN_FULL;
               out_last_in = cnt_last;
            end
            default: begin
               out_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff    <= MASTER_VOLUME_RESET;
         max_ff       <= MAX_NOTE_STEPS_RESET;
         global_ff    <= 1'b0;
         time_ff      <= '0;
         cnt_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            vol_ff[i] <= VOLUME_RESET;
         end
      end else begin
         master_ff    <= master_in;
         max_ff       <= max_in;
         global_ff    <= global_in;
         time_ff      <= time_in;
         cnt_ff       <= cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         out_valid_ff <= out_valid_in;
         if (cmd.msg_commit && vol_ctl && ch_ok) begin
            vol_ff[ch_idx] <= d2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      st_ff       <= st_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      el_ff       <= el_in;
      key_ff      <= key_in;
      mask_ff     <= mask_in;
      rel_ff      <= rel_in;
      cmp_ch_ff   <= cmp_ch_in;
      out_st_ff   <= out_st_in;
      out_d1_ff   <= out_d1_in;
      out_d2_ff   <= out_d2_in;
      out_len_ff  <= out_len_in;
      out_last_ff <= out_last_in;
   end

   assign status.command     = cmd_ff;
   assign status.key_ok      = key_ok;
   assign status.global_mode = global_ff;
   assign status.rel_empty   = rel_ff == '0;
   assign status.cnt_last    = cnt_last;
   assign status.slot_free   = slot_free;

   assign rsp_tvalid          = out_valid_ff;
   assign rsp_out_status      = out_st_ff;
   assign rsp_out_data_first  = out_d1_ff;
   assign rsp_out_data_second = out_d2_ff;
   assign rsp_out_length      = out_len_ff;
   assign rsp_last_of_run     = out_last_ff;

endmodule

// ----- hw/rtl/mhnt_ctrl.sv -----
// Controller state machine sequencing one request at a time through the datapath.
`timescale 1ns / 1ps

module mhnt_ctrl import mhnt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DECODE   = 9'b000000010,
      S_LOAD     = 9'b000000100,
      S_MSG      = 9'b000001000,
      S_SCAN     = 9'b000010000,
      S_SCAN_END = 9'b000100000,
      S_EMIT     = 9'b001000000,
      S_FINISH   = 9'b010000000,
      S_REFRESH  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.emit_sel = EMIT_MESSAGE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.command)
               CMD_MESSAGE: begin
                  cmd.act_rd = 1'b1;
                  state_in   = S_LOAD;
               end
               CMD_ADVANCE: begin
                  cmd.time_adv = 1'b1;
                  state_in     = S_IDLE;
               end
               CMD_CHECK: begin
                  cmd.act_rd = status.key_ok;
                  state_in   = status.key_ok ? S_LOAD : S_IDLE;
               end
               CMD_STOP: begin
                  cmd.act_rd     = status.key_ok;
                  cmd.time_clear = !status.key_ok;
                  state_in       = status.key_ok ? S_LOAD : S_IDLE;
               end
               CMD_REFRESH: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = status.global_mode ? S_IDLE : S_REFRESH;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_LOAD: begin
            cmd.load_mask = 1'b1;
            case (status.command)
               CMD_MESSAGE: begin
                  state_in = S_MSG;
               end
               CMD_CHECK: begin
                  cmd.rel_clr = 1'b1;
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_SCAN;
               end
               default: begin
                  cmd.rel_load_act = 1'b1;
                  state_in         = S_EMIT;
               end
            endcase
         end
         S_MSG: begin
            if (status.slot_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_sel   = EMIT_MESSAGE;
               cmd.msg_commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.cnt_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.rel_empty) begin
               state_in = S_FINISH;
            end else if (status.slot_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_NOTE_OFF;
            end
         end
         S_FINISH: begin
            cmd.finish_write = 1'b1;
            cmd.time_clear   = status.command == CMD_STOP;
            state_in         = S_IDLE;
         end
         S_REFRESH: begin
            if (status.slot_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_VOLUME;
               if (status.cnt_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.cnt_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/midi_hanging_note_tracker_core.sv -----
// MIDI hanging note tracker: top level joining controller and datapath.
// Usage:
//   req_* carries one request (message, time advance, key check, key stop or
//   volume refresh); rsp_* returns the MIDI messages it causes, rsp_tlast on
//   the final one. csr_* writes master volume, note limit and volume mode;
//   write them only while the block is idle, which the block does not enforce.
// Sequencing (one request at a time, req_tready high only when idle):
//   message   decode and key mask load, then one response in the output register.
//   advance   decode only, no response.
//   check     decode, mask load and channel scan, then one note-off per released
//             note; the start-time memory is read one channel per cycle.
//   stop      decode and mask load, then one note-off per released note.
//   refresh   one volume message per cycle unless stalled; none in global mode.
// Reset clears the key table (valid bit per key), time and volumes at once;
// no clearing pass. A stalled rsp_tready holds the output register and the
// controller waits before each further response; a finished response may
// wait in the output register while the next request is accepted.
`timescale 1ns / 1ps

module midi_hanging_note_tracker_core import mhnt_pkg::*; #(
   parameter int KEY_COUNT     = 128,
   parameter int CHANNEL_COUNT = 16,
   parameter int TIME_BITS     = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // status[7:0], data_first[14:8], data_second[21:15], elapsed_steps[37:22],
   // key_index[44:38], zero fill [47:45]
   input  logic [47:0]               req_tdata,
   // command[2:0]
   input  logic [2:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // out_status[7:0], out_data_first[14:8], out_data_second[21:15], out_length[23:22]
   output logic [23:0]               rsp_tdata,
   output logic                      rsp_tlast,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [7:0]    out_status;
   logic [6:0]    out_d1, out_d2;
   logic [1:0]    out_len;

   mhnt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mhnt_datapath #(
      .KEY_COUNT     (KEY_COUNT),
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .TIME_BITS     (TIME_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_command         (req_tuser),
      .req_status_byte     (req_tdata[7:0]),
      .req_data_first      (req_tdata[14:8]),
      .req_data_second     (req_tdata[21:15]),
      .req_elapsed_steps   (req_tdata[37:22]),
      .req_key_index       (req_tdata[44:38]),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .cmd                 (cmd),
      .status              (status),
      .rsp_tready          (rsp_tready),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_out_status      (out_status),
      .rsp_out_data_first  (out_d1),
      .rsp_out_data_second (out_d2),
      .rsp_out_length      (out_len),
      .rsp_last_of_run     (rsp_tlast)
   );

   assign rsp_tdata = {out_len, out_d2, out_d1, out_status};

endmodule

// ----- hw/rtl/mhnt_checker.sv -----
// Port-level assertions for the hanging note tracker, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mhnt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled response changed")
   `ASSERT_NXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted while busy")
   `ASSERT_IMP(a_program_short, clock, reset, rsp_tvalid && (rsp_tdata[7:4] == 4'hC), (rsp_tdata[23:22] == 2'd2) && (rsp_tdata[21:15] == 7'd0), "program change not short")
   `ASSERT_IMP(a_other_full, clock, reset, rsp_tvalid && (rsp_tdata[7:4] != 4'hC), rsp_tdata[23:22] == 2'd3, "message length not three")

endmodule

bind midi_hanging_note_tracker_core mhnt_checker u_mhnt_checker (.*);

// ----- tb/sv/midi_hanging_note_tracker_core_tb.sv -----
// Self-checking testbench for the MIDI hanging note tracker core with a built-in note tracker.
`timescale 1ns / 1ps

module midi_hanging_note_tracker_core_tb;
   import mhnt_pkg::*;

   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         HOLD_AFTER   = 120;
   localparam int         PHASE_ITEMS  = 75;
   localparam logic [2:0] CMD_SPARE    = 3'd7;

   typedef struct {
      logic [2:0]  cmd;
      logic [47:0] data;
   } midi_req_type;

   typedef struct packed {
      logic [7:0] status;
      logic [6:0] data_first;
      logic [6:0] data_second;
      logic [1:0] length;
      logic       last;
   } midi_msg_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // status[7:0], data_first[14:8], data_second[21:15], elapsed_steps[37:22],
   // key_index[44:38], zero fill [47:45]
   logic [47:0] req_tdata  = '0;
   // command[2:0]
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // out_status[7:0], out_data_first[14:8], out_data_second[21:15], out_length[23:22]
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en  = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   midi_req_type pending_reqs [$];
   midi_msg_type expected_msgs [$];

   // tracker state
   logic [15:0] key_active [128];
   logic [31:0] note_start [128][16];
   logic [31:0] now_steps;
   logic [6:0]  chan_volume [16];
   logic [8:0]  vol_master  = MASTER_VOLUME_RESET;
   logic [31:0] note_limit  = MAX_NOTE_STEPS_RESET;
   logic        vol_global  = 1'b0;

   logic        tx_idle = 1'b1;
   logic        rx_idle = 1'b1;
   logic        rx_hold = 1'b0;
   int          tx_wait;
   int          rx_wait;
   int          reqs_queued   = 0;
   int          reqs_accepted = 0;
   int          msgs_checked  = 0;
   int          notes_released = 0;
   int          settings_run  = 0;
   int          mismatches    = 0;
   int          cycle_count   = 0;

   midi_hanging_note_tracker_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report(input string what);
      $display("MISMATCH: %s", what);
      mismatches++;
   endtask

   function automatic logic [6:0] scaled_volume(input logic [6:0] level);
      int unsigned prod;
      prod = (32'(level) * 32'(vol_master) * 32'd3) >> 10;
      return (prod > 127) ? 7'd127 : 7'(prod);
   endfunction

   // Expected messages caused by one request; updates the tracked state.
   task automatic track_request(input logic [2:0] cmd, input logic [47:0] d);
      midi_msg_type batch [16];
      int          n;
      logic [7:0]  st;
      logic [3:0]  kind;
      logic [3:0]  ch;
      logic [6:0]  d1;
      logic [6:0]  d2;
      logic [6:0]  key;
      logic [15:0] el;
      logic [31:0] held;
      n    = 0;
      st   = d[7:0];
      d1   = d[14:8];
      d2   = d[21:15];
      el   = d[37:22];
      key  = d[44:38];
      kind = st[7:4];
      ch   = st[3:0];
      case (cmd)
         CMD_MESSAGE: begin
            batch[0].status      = st;
            batch[0].data_first  = d1;
            batch[0].data_second = (kind == TYPE_PROGRAM) ? 7'd0 : d2;
            batch[0].length      = (kind == TYPE_PROGRAM) ? LEN_SHORT : LEN_FULL;
            batch[0].last        = 1'b0;
            if (kind == TYPE_CONTROL && d1 == CTRL_VOLUME && !vol_global) begin
               chan_volume[ch] = d2;
               batch[0].data_second = scaled_volume(d2);
            end
            n = 1;
            if (kind == TYPE_NOTE_OFF || (kind == TYPE_NOTE_ON && d2 == 7'd0)) begin
               key_active[d1][ch] = 1'b0;
            end else if (kind == TYPE_NOTE_ON) begin
               key_active[d1][ch] = 1'b1;
               note_start[d1][ch] = now_steps;
            end
         end
         CMD_ADVANCE: now_steps = now_steps + 32'(el);
         CMD_CHECK, CMD_STOP: begin
            for (int c = 0; c < 16; c++) begin
               if (key_active[key][c]) begin
                  held = now_steps - note_start[key][c];
                  if (cmd == CMD_STOP || held > note_limit) begin
                     batch[n].status      = {TYPE_NOTE_OFF, 4'(c)};
                     batch[n].data_first  = key;
                     batch[n].data_second = 7'd0;
                     batch[n].length      = LEN_FULL;
                     batch[n].last        = 1'b0;
                     n++;
                     key_active[key][c] = 1'b0;
                     notes_released++;
                  end
               end
            end
            if (cmd == CMD_STOP) now_steps = '0;
         end
         CMD_REFRESH: begin
            if (!vol_global) begin
               for (int c = 0; c < 16; c++) begin
                  batch[c].status      = {TYPE_CONTROL, 4'(c)};
                  batch[c].data_first  = CTRL_VOLUME;
                  batch[c].data_second = scaled_volume(chan_volume[c]);
                  batch[c].length      = LEN_FULL;
                  batch[c].last        = 1'b0;
               end
               n = 16;
            end
         end
         default: ;
      endcase
      if (n > 0) batch[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_msgs.push_back(batch[i]);
   endtask

   always @(posedge clock) begin : drive_requests
      midi_req_type item;
      logic         next_valid;
      if (reset) begin
         for (int k = 0; k < 128; k++) key_active[k] = '0;
         for (int c = 0; c < 16; c++) chan_volume[c] = VOLUME_RESET;
         now_steps = '0;
         tx_wait = 0;
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            track_request(req_tuser, req_tdata);
            reqs_accepted++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (tx_wait > 0) begin
               tx_wait--;
            end else if (pending_reqs.size() != 0) begin
               item = pending_reqs.pop_front();
               req_tuser <= item.cmd;
               req_tdata <= item.data;
               next_valid = 1'b1;
               tx_wait = tx_idle ? $urandom_range(0, 8) : 0;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   always @(posedge clock) begin : check_responses
      midi_msg_type got;
      midi_msg_type want;
      if (reset) begin
         rx_wait = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[14:8], rsp_tdata[21:15], rsp_tdata[23:22],
                   rsp_tlast};
            msgs_checked++;
            if (expected_msgs.size() == 0) begin
               report($sformatf("unexpected message st=%h d1=%h d2=%h len=%0d last=%b",
                                got.status, got.data_first, got.data_second, got.length,
                                got.last));
            end else begin
               want = expected_msgs.pop_front();
               if (got !== want)
                  report($sformatf({"st=%h/%h d1=%h/%h d2=%h/%h len=%0d/%0d last=%b/%b",
                                    " (got/exp)"},
                                   got.status, want.status, got.data_first, want.data_first,
                                   got.data_second, want.data_second, got.length,
                                   want.length, got.last, want.last));
            end
            rx_wait = rx_idle ? $urandom_range(0, 8) : 0;
         end
         if (rx_hold) begin
            rsp_tready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // long receiver stall while requests keep coming
   initial begin
      wait (reqs_accepted >= HOLD_AFTER);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   task automatic queue_req(input logic [2:0] cmd, input logic [7:0] st, input logic [6:0] d1,
                            input logic [6:0] d2, input logic [15:0] el, input logic [6:0] key);
      midi_req_type item;
      item.cmd  = cmd;
      item.data = {3'b000, key, el, d2, d1, st};
      pending_reqs.push_back(item);
      reqs_queued++;
   endtask

   function automatic logic [6:0] hot_key();
      if ($urandom_range(0, 4) == 0) return 7'($urandom);
      case ($urandom_range(0, 4))
         0: return 7'd0;
         1: return 7'd60;
         2: return 7'd64;
         3: return 7'd100;
         default: return 7'd127;
      endcase
   endfunction

   task automatic add_random_req();
      int          pick;
      logic [7:0]  st;
      logic [6:0]  d1;
      logic [6:0]  d2;
      logic [6:0]  key;
      logic [15:0] el;
      logic [3:0]  ch;
      st   = 8'($urandom);
      d1   = 7'($urandom);
      d2   = 7'($urandom);
      el   = 16'($urandom);
      key  = 7'($urandom);
      ch   = 4'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         d2 = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
         queue_req(CMD_MESSAGE, {TYPE_NOTE_ON, ch}, hot_key(), d2, el, key);
      end else if (pick < 50) begin
         queue_req(CMD_MESSAGE, {TYPE_NOTE_OFF, ch}, hot_key(), d2, el, key);
      end else if (pick < 60) begin
         case ($urandom_range(0, 4))
            0, 1: el = 16'($urandom_range(0, 600));
            2, 3: el = 16'($urandom_range(0, 4000));
            default: ;
         endcase
         queue_req(CMD_ADVANCE, st, d1, d2, el, key);
      end else if (pick < 72) begin
         queue_req(CMD_CHECK, st, d1, d2, el, hot_key());
      end else if (pick < 77) begin
         queue_req(CMD_STOP, st, d1, d2, el, hot_key());
      end else if (pick < 81) begin
         queue_req(CMD_REFRESH, st, d1, d2, el, key);
      end else if (pick < 87) begin
         queue_req(CMD_MESSAGE, {TYPE_CONTROL, ch},
                   ($urandom_range(0, 3) != 0) ? CTRL_VOLUME : d1, d2, el, key);
      end else if (pick < 91) begin
         queue_req(CMD_MESSAGE, {TYPE_PROGRAM, ch}, d1, d2, el, key);
      end else begin
         queue_req(3'($urandom_range(0, 7)), st, d1, d2, el, key);
      end
   endtask

   task automatic wait_idle();
      while (reqs_accepted != reqs_queued || expected_msgs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [8:0] master, input logic [31:0] limit,
                            input logic global_mode, input logic tx_gaps, input logic rx_gaps);
      wait_idle();
      write_reg(CSR_MASTER_VOLUME, 32'(master));
      write_reg(CSR_MAX_NOTE_STEPS, limit);
      write_reg(CSR_GLOBAL_VOLUME, 32'(global_mode));
      vol_master = master;
      note_limit = limit;
      vol_global = global_mode;
      tx_idle    = tx_gaps;
      rx_idle    = rx_gaps;
      settings_run++;
      for (int i = 0; i < PHASE_ITEMS; i++) add_random_req();
   endtask

   initial begin
      while (reset) @(posedge clock);
      settings_run = 1;

      queue_req(CMD_MESSAGE, 8'h90, 7'd0, 7'd127, '0, '0);
      queue_req(CMD_MESSAGE, 8'h9F, 7'd127, 7'd1, '0, '0);
      queue_req(CMD_MESSAGE, 8'h9F, 7'd127, 7'd0, '0, '0);   // zero velocity releases
      queue_req(CMD_MESSAGE, 8'h9F, 7'd127, 7'd64, '0, '0);
      queue_req(CMD_MESSAGE, 8'h95, 7'd0, 7'd100, '0, '0);
      queue_req(CMD_MESSAGE, 8'h80, 7'd0, 7'd127, '0, '0);
      queue_req(CMD_MESSAGE, 8'hC3, 7'h55, 7'h7F, '0, '0);
      queue_req(CMD_MESSAGE, 8'hB2, CTRL_VOLUME, 7'd127, '0, '0);
      queue_req(CMD_MESSAGE, 8'hB2, CTRL_VOLUME, 7'd0, '0, '0);
      queue_req(CMD_MESSAGE, 8'hB1, 7'd10, 7'd99, '0, '0);
      queue_req(CMD_MESSAGE, 8'h45, 7'h12, 7'h34, '0, '0);    // data byte as status
      queue_req(CMD_MESSAGE, 8'hFF, 7'h7F, 7'h7F, '0, '0);
      queue_req(CMD_MESSAGE, 8'h00, 7'h00, 7'h00, '0, '0);
      queue_req(CMD_ADVANCE, '0, '0, '0, 16'd1000, '0);
      queue_req(CMD_CHECK, '0, '0, '0, '0, 7'd0);
      queue_req(CMD_ADVANCE, '0, '0, '0, 16'hFFFF, '0);
      queue_req(CMD_CHECK, '0, '0, '0, '0, 7'd0);
      queue_req(CMD_CHECK, '0, '0, '0, '0, 7'd127);
      queue_req(CMD_STOP, '0, '0, '0, '0, 7'd5);               // nothing held
      queue_req(CMD_MESSAGE, 8'h93, 7'd5, 7'd10, '0, '0);
      queue_req(CMD_MESSAGE, 8'h99, 7'd5, 7'd20, '0, '0);
      queue_req(CMD_STOP, '0, '0, '0, '0, 7'd5);
      queue_req(CMD_REFRESH, '0, '0, '0, '0, '0);
      queue_req(CMD_SPARE, 8'hFF, 7'h7F, 7'h7F, 16'hFFFF, 7'h7F);
      queue_req(CMD_CHECK, '0, '0, '0, '0, 7'd64);

      run_phase(9'd0, 32'd0, 1'b0, 1'b1, 1'b1);
      run_phase(9'd256, 32'd900, 1'b0, 1'b1, 1'b1);
      run_phase(9'd256, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
      run_phase(9'($urandom_range(0, 256)), 32'($urandom_range(200, 3000)), 1'b0, 1'b1, 1'b0);
      run_phase(9'd1, 32'd1, 1'b1, 1'b0, 1'b1);
      run_phase(9'($urandom_range(0, 256)), MAX_NOTE_STEPS_RESET, 1'b0, 1'b1, 1'b1);
      wait_idle();

      $display("Ran %0d requests under %0d register settings, %0d messages checked",
               reqs_accepted, settings_run, msgs_checked);
      $display("Tracker released %0d notes; receiver held off for %0d cycles once",
               notes_released, HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mhnt_pkg.sv
hw/rtl/mhnt_ram.sv
hw/rtl/mhnt_datapath.sv
hw/rtl/mhnt_ctrl.sv
hw/rtl/midi_hanging_note_tracker_core.sv
hw/rtl/mhnt_checker.sv
tb/sv/midi_hanging_note_tracker_core_tb.sv
